>>> rtl/cdn_pkg.sv
// Shared types and constants for the civil date / day number converter.
`timescale 1ns / 1ps

package cdn_pkg;

    typedef struct packed {
        logic        kind;
        logic [13:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [22:0] day_number_in;
    } cdn_req_t;

    typedef struct packed {
        logic [22:0] day_number_out;
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic        range_error;
    } cdn_res_t;

    localparam logic KIND_TO_NUMBER = 1'b0;
    localparam logic KIND_TO_DATE   = 1'b1;

    localparam logic [22:0] DN_BASE  = 23'd1721119;
    localparam logic [22:0] DN_MIN   = 23'd1721426;
    localparam logic [22:0] DN_MAX   = 23'd5373484;
    localparam logic [13:0] YEAR_MAX = 14'd9999;
    localparam logic [17:0] CYC400   = 18'd146097;
    localparam logic [10:0] CYC4     = 11'd1461;
    localparam logic [7:0]  MONTH5   = 8'd153;

    // reciprocals rounded up; each shift keeps the quotient exact over its operand range
    localparam int DIV100_SHIFT = 20;
    localparam logic [13:0] DIV100_RCP =
        14'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);
    localparam int DIV5_SHIFT = 13;
    localparam logic [10:0] DIV5_RCP =
        11'(((64'd1 << DIV5_SHIFT) + 64'd4) / 64'd5);
    localparam int DIV400_SHIFT = 42;
    localparam logic [24:0] DIV400_RCP =
        25'(((64'd1 << DIV400_SHIFT) + 64'd146096) / 64'd146097);
    localparam int DIV4_SHIFT = 28;
    localparam logic [17:0] DIV4_RCP =
        18'(((64'd1 << DIV4_SHIFT) + 64'd1460) / 64'd1461);
    localparam int DIV153_SHIFT = 18;
    localparam logic [10:0] DIV153_RCP =
        11'(((64'd1 << DIV153_SHIFT) + 64'd152) / 64'd153);

    localparam int PIPE_STAGES = 9;
    localparam int DATE_STAGES = 5;
    localparam int PIPE_LAT    = PIPE_STAGES + 1;

endpackage

>>> rtl/civil_date_day_number_convert.sv
// Top level of the civil date / day number converter.
//
// Commands enter on start with the request struct; kind picks the direction.
// Kind 0 turns year, month and day into a civil day number; kind 1 turns a
// day number back into year, month and day. Years outside 1..9999, or day
// numbers outside 0001-01-01 .. 9999-12-31, raise range_error with all
// other result fields zero.
// busy stays low: a transaction is taken on every cycle that start is high.
// Each transaction yields one result, shown on result for a single cycle with
// done high. Throughput is one transaction per cycle. The day number to date
// chain has nine stages (among them three reciprocal divisions, each a
// multiply stage and a remainder stage) and is followed by the output
// register. The date to day number chain is five stages, padded to match,
// so results leave in the order they came in.
// The receiver cannot stall; results are never held.
// Reset clears all valid bits, so no result appears from before reset.
`timescale 1ns / 1ps

module civil_date_day_number_convert
    import cdn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  cdn_req_t request,
    output logic     done,
    output cdn_res_t result
);

    logic     num_valid, date_valid;
    logic     num_res_valid, date_res_valid;
    cdn_res_t num_res, date_res;
    logic     done_reg, done_next;
    cdn_res_t result_reg, result_next;

    assign busy       = 1'b0;
    assign num_valid  = start && !busy && (request.kind == KIND_TO_NUMBER);
    assign date_valid = start && !busy && (request.kind == KIND_TO_DATE);

    cdn_date_to_num u_to_num (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (num_valid),
        .request   (request),
        .res_valid (num_res_valid),
        .res       (num_res)
    );

    cdn_num_to_date u_to_date (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (date_valid),
        .request   (request),
        .res_valid (date_res_valid),
        .res       (date_res)
    );

    always_comb
    begin
        done_next   = num_res_valid || date_res_valid;
        result_next = num_res_valid ? num_res : date_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        !(num_res_valid && date_res_valid))
        else $error("both conversion pipelines delivered at once");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("accepted transaction produced no result on time");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.range_error) |->
            (result.day_number_out == 23'd0 && result.year_out == 14'd0 &&
             result.month_out == 4'd0 && result.day_out == 5'd0))
        else $error("range error result carries non-zero fields");

    a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.range_error && result.day_number_out == 23'd0) |->
            (result.month_out >= 4'd1 && result.month_out <= 4'd12 &&
             result.day_out != 5'd0 && result.year_out != 14'd0 &&
             result.year_out <= YEAR_MAX))
        else $error("converted date out of range");

endmodule

>>> rtl/cdn_date_to_num.sv
// Date to day number pipeline, padded to the common pipeline depth.
`timescale 1ns / 1ps

module cdn_date_to_num
    import cdn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     valid,
    input  cdn_req_t request,
    output logic     res_valid,
    output cdn_res_t res
);

    localparam int PAD = PIPE_STAGES - DATE_STAGES;

    logic [DATE_STAGES-1:0] vld_reg;
    logic [DATE_STAGES-1:0] err_reg;
    logic                   err_next;

    logic [13:0] y1_reg, y1_next, y2_reg;
    logic [3:0]  m1_reg, m1_next, m2_reg;
    logic [4:0]  day1_reg, day2_reg, day3_reg;
    logic [6:0]  c2_reg, c2_next;
    logic [27:0] c_prod;
    logic [6:0]  yy3_reg, yy3_next;
    logic [22:0] a3_reg, a3_next;
    logic [24:0] a_prod;
    logic [10:0] mt3_reg, mt3_next;
    logic [13:0] y_rem;
    logic [15:0] b4_reg, b4_next;
    logic [17:0] b_prod;
    logic [8:0]  mq4_reg, mq4_next;
    logic [21:0] mq_prod;
    logic [22:0] p4_reg, p4_next;
    logic [22:0] n5_reg, n5_next;
    cdn_res_t    res5;

    cdn_res_t        pad_res_reg [PAD];
    logic [PAD-1:0]  pad_vld_reg;

    always_comb
    begin
        err_next = (request.year_in == 14'd0) || (request.year_in > YEAR_MAX);
        if (request.month_in > 4'd2)
        begin
            m1_next = request.month_in - 4'd3;
            y1_next = request.year_in;
        end
        else
        begin
            m1_next = request.month_in + 4'd9;
            y1_next = request.year_in - 14'd1;
        end

        c_prod  = 28'(y1_reg) * 28'(DIV100_RCP);
        c2_next = c_prod[DIV100_SHIFT+6:DIV100_SHIFT];

        y_rem    = y2_reg - 14'(14'(c2_reg) * 14'd100);
        yy3_next = y_rem[6:0];
        a_prod   = 25'(c2_reg) * 25'(CYC400);
        a3_next  = a_prod[24:2];
        mt3_next = 11'(11'(m2_reg) * 11'(MONTH5)) + 11'd2;

        b_prod   = 18'(yy3_reg) * 18'(CYC4);
        b4_next  = b_prod[17:2];
        mq_prod  = 22'(mt3_reg) * 22'(DIV5_RCP);
        mq4_next = mq_prod[DIV5_SHIFT+8:DIV5_SHIFT];
        p4_next  = 23'(day3_reg) + a3_reg + DN_BASE;

        n5_next = p4_reg + 23'(b4_reg) + 23'(mq4_reg);

        res5                = '0;
        res5.range_error    = err_reg[DATE_STAGES-1];
        res5.day_number_out = err_reg[DATE_STAGES-1] ? 23'd0 : n5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            pad_vld_reg <= '0;
        end
        else
        begin
            vld_reg     <= {vld_reg[DATE_STAGES-2:0], valid};
            pad_vld_reg <= {pad_vld_reg[PAD-2:0], vld_reg[DATE_STAGES-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg  <= {err_reg[DATE_STAGES-2:0], err_next};
        y1_reg   <= y1_next;
        m1_reg   <= m1_next;
        day1_reg <= request.day_in;
        y2_reg   <= y1_reg;
        m2_reg   <= m1_reg;
        day2_reg <= day1_reg;
        c2_reg   <= c2_next;
        yy3_reg  <= yy3_next;
        a3_reg   <= a3_next;
        mt3_reg  <= mt3_next;
        day3_reg <= day2_reg;
        b4_reg   <= b4_next;
        mq4_reg  <= mq4_next;
        p4_reg   <= p4_next;
        n5_reg   <= n5_next;
        pad_res_reg[0] <= res5;
        for (int i = 1; i < PAD; i++)
        begin
            pad_res_reg[i] <= pad_res_reg[i-1];
        end
    end

    assign res_valid = pad_vld_reg[PAD-1];
    assign res       = pad_res_reg[PAD-1];

endmodule

>>> rtl/cdn_num_to_date.sv
// Day number to date pipeline.
`timescale 1ns / 1ps

module cdn_num_to_date
    import cdn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     valid,
    input  cdn_req_t request,
    output logic     res_valid,
    output cdn_res_t res
);

    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] err_reg;
    logic                   err_next;

    logic [22:0] j;
    logic [23:0] x1_reg, x1_next, x2_reg;
    logic [48:0] cy_prod;
    logic [6:0]  cy2_reg, cy2_next, cy3_reg, cy4_reg;
    logic [23:0] r_full;
    logic [17:0] t3_reg, t3_next, t4_reg;
    logic [35:0] yc_prod;
    logic [6:0]  yc4_reg, yc4_next;
    logic [17:0] d_full;
    logic [10:0] d_sum;
    logic [8:0]  d5_reg, d5_next;
    logic [13:0] y5_reg, y5_next, y6_reg, y7_reg;
    logic [10:0] u6_reg, u6_next, u7_reg;
    logic [21:0] m_prod;
    logic [3:0]  m7_reg, m7_next;
    logic [10:0] m_rem;
    logic [7:0]  dd8_reg, dd8_next;
    logic [3:0]  mo8_reg, mo8_next;
    logic [13:0] yr8_reg, yr8_next;
    logic [18:0] day_prod;
    cdn_res_t    res_reg, res_next;

    always_comb
    begin
        err_next = (request.day_number_in < DN_MIN) || (request.day_number_in > DN_MAX);
        j        = request.day_number_in - DN_BASE;
        x1_next  = {j[21:0], 2'b00} - 24'd1;

        cy_prod  = 49'(x1_reg) * 49'(DIV400_RCP);
        cy2_next = cy_prod[DIV400_SHIFT+6:DIV400_SHIFT];

        r_full  = x2_reg - 24'(24'(cy2_reg) * 24'(CYC400));
        t3_next = {r_full[17:2], 2'b11};

        yc_prod  = 36'(t3_reg) * 36'(DIV4_RCP);
        yc4_next = yc_prod[DIV4_SHIFT+6:DIV4_SHIFT];

        d_full  = t4_reg - 18'(18'(yc4_reg) * 18'(CYC4));
        d_sum   = d_full[10:0] + 11'd4;
        d5_next = d_sum[10:2];
        y5_next = 14'(14'(cy4_reg) * 14'd100) + 14'(yc4_reg);

        u6_next = 11'(11'(d5_reg) * 11'd5) - 11'd3;

        m_prod  = 22'(u6_reg) * 22'(DIV153_RCP);
        m7_next = m_prod[DIV153_SHIFT+3:DIV153_SHIFT];

        m_rem    = u7_reg - 11'(11'(m7_reg) * 11'(MONTH5));
        dd8_next = m_rem[7:0] + 8'd5;
        if (m7_reg < 4'd10)
        begin
            mo8_next = m7_reg + 4'd3;
            yr8_next = y7_reg;
        end
        else
        begin
            mo8_next = m7_reg - 4'd9;
            yr8_next = y7_reg + 14'd1;
        end

        day_prod             = 19'(dd8_reg) * 19'(DIV5_RCP);
        res_next             = '0;
        res_next.range_error = err_reg[PIPE_STAGES-2];
        if (!err_reg[PIPE_STAGES-2])
        begin
            res_next.year_out  = yr8_reg;
            res_next.month_out = mo8_reg;
            res_next.day_out   = day_prod[DIV5_SHIFT+4:DIV5_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_STAGES-2:0], valid};
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg <= {err_reg[PIPE_STAGES-2:0], err_next};
        x1_reg  <= x1_next;
        x2_reg  <= x1_reg;
        cy2_reg <= cy2_next;
        cy3_reg <= cy2_reg;
        t3_reg  <= t3_next;
        cy4_reg <= cy3_reg;
        t4_reg  <= t3_reg;
        yc4_reg <= yc4_next;
        d5_reg  <= d5_next;
        y5_reg  <= y5_next;
        u6_reg  <= u6_next;
        y6_reg  <= y5_reg;
        m7_reg  <= m7_next;
        u7_reg  <= u6_reg;
        y7_reg  <= y6_reg;
        dd8_reg <= dd8_next;
        mo8_reg <= mo8_next;
        yr8_reg <= yr8_next;
        res_reg <= res_next;
    end

    assign res_valid = vld_reg[PIPE_STAGES-1];
    assign res       = res_reg;

endmodule
